>>> sv/vtlc_pkg.sv
// vtlc_pkg: shared types and constants of the video test line classifier
// depends on nothing; imported by every module of the block but vtlc_divider
package vtlc_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int LINE_NUM_W     = 10;
   localparam int LINE_LEN_W     = 13;
   localparam int START_W        = 12;
   localparam int WIDTH_W        = 13;
   localparam int WIN_W          = 14;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 13;
   localparam int REQ_TDATA_W    = 32;
   localparam int RSP_TDATA_W    = 176;
   localparam int RESP_OUT_COUNT = 6;
   localparam int RESP_W         = 16;
   localparam int CONTRAST_W     = 23;
   localparam int BW_STEP_W      = 3;
   localparam int TYPE_W         = 2;
   localparam int COUNT_W        = 16;
   localparam int CROSS_W        = 5;
   localparam int RISE_W         = 4;

   localparam int MIN_LINE_LENGTH = 64;
   localparam int LEVEL_LIMIT     = 10000;
   localparam int CROSS_LIMIT     = 20;
   localparam int RISE_STEP       = 1000;
   localparam int RISE_LIMIT      = 4;
   localparam int STAIR_LAST      = 9;
   localparam int STAIR_STEPS     = 10;
   localparam int CONTRAST_SCALE  = 100;
   localparam int RECIP_SHIFT     = 16;
   localparam int RECIP_ONE       = 65536;

   localparam logic [CSR_ADDR_W-1:0] REG_LINE_LENGTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_START = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_WIDTH = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BAR_START   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BAR_WIDTH   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_LINE  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LAST_LINE   = 3'd6;

   localparam logic [TYPE_W-1:0] TYPE_NONE       = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_PULSE_BAR  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_MULTIBURST = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_STAIRCASE  = 2'd3;

   typedef enum logic [2:0] {
      ST_STREAM,
      ST_PULSE,
      ST_BAR,
      ST_PORCH,
      ST_CONTRAST,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      OP_PULSE,
      OP_BAR,
      OP_PORCH,
      OP_CONTRAST
   } div_op_type;

   typedef struct packed {
      logic       take;
      logic       div_go;
      div_op_type op;
      logic       commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic line_end;
      logic test_line;
      logic div_done;
      logic go_porch;
      logic black_nz;
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/vtlc_divider.sv
// vtlc_divider: restoring divider, signed numerator by unsigned denominator,
// one quotient bit per cycle, truncates toward zero; uses vtlc_pkg nothing
module vtlc_divider #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic signed [NUM_W-1:0] numer,
   input  logic        [DEN_W-1:0] denom,
   output logic                    done,
   output logic signed [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial    = {rem_ff, mag_ff[NUM_W-1]};
      fits     = trial >= {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         mag_in = {mag_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (go && !done_ff) begin
         busy_in = 1'b1;
         neg_in  = numer[NUM_W-1];
         mag_in  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

>>> sv/vtlc_datapath.sv
// vtlc_datapath: configuration registers, per-line gathering, line-end
// arithmetic and result register; uses vtlc_pkg and vtlc_divider
module vtlc_datapath #(
   parameter int MAX_LINE_SAMPLES = 4096,
   parameter int SEGMENT_COUNT    = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [vtlc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [vtlc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [vtlc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [vtlc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  vtlc_pkg::ctrl_cmd_type               cmd,
   output vtlc_pkg::dp_status_type              status
);
   import vtlc_pkg::*;

   localparam int POS_W      = $clog2(MAX_LINE_SAMPLES);
   localparam int LEN_W      = POS_W + 1;
   localparam int CMP_W      = (LEN_W > LINE_LEN_W) ? LEN_W : LINE_LEN_W;
   localparam int ACC_W      = POS_W + SAMPLE_W;
   localparam int DIV_W      = (ACC_W > 24) ? ACC_W : 24;
   localparam int IDX_W      = $clog2(SEGMENT_COUNT + 1);
   localparam int SEL_W      = $clog2(SEGMENT_COUNT);
   localparam int SEG_RECIP  = (RECIP_ONE + SEGMENT_COUNT - 1) / SEGMENT_COUNT;
   localparam int STR_RECIP  = (RECIP_ONE + STAIR_STEPS - 1) / STAIR_STEPS;
   localparam int PROD_W     = LEN_W + RECIP_SHIFT + 1;

   function automatic logic in_window(logic [WIN_W-1:0] p, logic [WIN_W-1:0] start,
                                      logic [WIN_W-1:0] width);
      return (p >= start) && ((p - start) < width);
   endfunction

   // configuration
   logic [LINE_LEN_W-1:0] line_length_ff;
   logic [START_W-1:0]    pulse_start_ff, bar_start_ff;
   logic [WIDTH_W-1:0]    pulse_width_ff, bar_width_ff;
   logic [LINE_NUM_W-1:0] first_line_ff, last_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LEN_W'(1280);
         pulse_start_ff <= START_W'(220);
         pulse_width_ff <= WIDTH_W'(40);
         bar_start_ff   <= START_W'(400);
         bar_width_ff   <= WIDTH_W'(300);
         first_line_ff  <= LINE_NUM_W'(17);
         last_line_ff   <= LINE_NUM_W'(19);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_LINE_LENGTH: line_length_ff <= csr_wdata[LINE_LEN_W-1:0];
            REG_PULSE_START: pulse_start_ff <= csr_wdata[START_W-1:0];
            REG_PULSE_WIDTH: pulse_width_ff <= csr_wdata[WIDTH_W-1:0];
            REG_BAR_START:   bar_start_ff   <= csr_wdata[START_W-1:0];
            REG_BAR_WIDTH:   bar_width_ff   <= csr_wdata[WIDTH_W-1:0];
            REG_FIRST_LINE:  first_line_ff  <= csr_wdata[LINE_NUM_W-1:0];
            REG_LAST_LINE:   last_line_ff   <= csr_wdata[LINE_NUM_W-1:0];
            default: ;
         endcase
      end
   end

   // line geometry
   logic [CMP_W-1:0]  len_x;
   logic [LEN_W-1:0]  eff_len, act_start, act_end, act_len, step_w, seg_w;
   logic [LEN_W-1:0]  porch_start, porch_width, pos_x;
   logic [LEN_W+2:0]  len_times7;
   logic [PROD_W-1:0] step_prod, seg_prod;

   always_comb begin
      len_x = CMP_W'(line_length_ff);
      if (len_x < CMP_W'(MIN_LINE_LENGTH))       eff_len = LEN_W'(MIN_LINE_LENGTH);
      else if (len_x > CMP_W'(MAX_LINE_SAMPLES)) eff_len = LEN_W'(MAX_LINE_SAMPLES);
      else                                        eff_len = LEN_W'(len_x);
      act_start   = eff_len >> 3;
      len_times7  = (LEN_W+3)'(eff_len) * (LEN_W+3)'(7);
      act_end     = LEN_W'(len_times7 >> 3);
      act_len     = eff_len - act_start;
      step_prod   = PROD_W'(act_len) * PROD_W'(STR_RECIP);
      seg_prod    = PROD_W'(act_len) * PROD_W'(SEG_RECIP);
      step_w      = LEN_W'(step_prod >> RECIP_SHIFT);
      seg_w       = LEN_W'(seg_prod >> RECIP_SHIFT);
      porch_start = eff_len >> 4;
      porch_width = eff_len >> 5;
   end

   // per-line state
   logic [POS_W-1:0]                 pos_ff;
   logic signed [ACC_W-1:0]          pulse_acc_ff, bar_acc_ff, porch_acc_ff;
   logic [CROSS_W-1:0]               cross_ff;
   logic                             prev_sign_ff;
   logic signed [SAMPLE_W-1:0]       stair_lvl_ff;
   logic [RISE_W-1:0]                rise_ff;
   logic [LEN_W-1:0]                 stair_off_ff;
   logic [RISE_W-1:0]                stair_q_ff;
   logic signed [SAMPLE_W-1:0]       seg_min_ff, seg_max_ff;
   logic [LEN_W-1:0]                 seg_off_ff;
   logic [IDX_W-1:0]                 seg_idx_ff;
   logic [RESP_W-1:0]                pending_ff [SEGMENT_COUNT];
   logic                             test_ff;

   logic signed [SAMPLE_W-1:0] s_val;
   logic [LINE_NUM_W-1:0]      ln_val;
   logic signed [ACC_W-1:0]    s_ext;
   logic                       s_pos;
   logic signed [SAMPLE_W+1:0] rise_ref;
   logic signed [SAMPLE_W-1:0] new_min, new_max;
   logic [LEN_W-1:0]           stair_next;

   always_comb begin
      s_val      = $signed(req_tdata[SAMPLE_W-1:0]);
      ln_val     = req_tdata[SAMPLE_W +: LINE_NUM_W];
      s_ext      = ACC_W'(s_val);
      s_pos      = s_val > 0;
      pos_x      = LEN_W'(pos_ff);
      rise_ref   = (SAMPLE_W+2)'(stair_lvl_ff) + (SAMPLE_W+2)'(RISE_STEP);
      new_min    = (s_val < seg_min_ff) ? s_val : seg_min_ff;
      new_max    = (s_val > seg_max_ff) ? s_val : seg_max_ff;
      stair_next = stair_off_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.commit) begin
         pos_ff       <= '0;
         pulse_acc_ff <= '0;
         bar_acc_ff   <= '0;
         porch_acc_ff <= '0;
         cross_ff     <= '0;
         prev_sign_ff <= 1'b0;
         stair_lvl_ff <= '0;
         rise_ff      <= '0;
         stair_off_ff <= '0;
         stair_q_ff   <= '0;
         seg_min_ff   <= SAMPLE_W'(32767);
         seg_max_ff   <= SAMPLE_W'(-32768);
         seg_off_ff   <= '0;
         seg_idx_ff   <= '0;
         for (int k = 0; k < SEGMENT_COUNT; k++) pending_ff[k] <= '0;
      end else if (cmd.take) begin
         pos_ff <= status.line_end ? pos_ff : pos_ff + 1'b1;
         if (in_window(WIN_W'(pos_ff), WIN_W'(pulse_start_ff), WIN_W'(pulse_width_ff)))
            pulse_acc_ff <= pulse_acc_ff + s_ext;
         if (in_window(WIN_W'(pos_ff), WIN_W'(bar_start_ff), WIN_W'(bar_width_ff)))
            bar_acc_ff <= bar_acc_ff + s_ext;
         if (in_window(WIN_W'(pos_ff), WIN_W'(porch_start), WIN_W'(porch_width)))
            porch_acc_ff <= porch_acc_ff + s_ext;

         // zero crossings in the active part
         if (pos_x == act_start) begin
            prev_sign_ff <= s_pos;
         end else if (pos_x > act_start && pos_x < act_end) begin
            if (s_pos != prev_sign_ff && cross_ff != '1) cross_ff <= cross_ff + 1'b1;
            prev_sign_ff <= s_pos;
         end

         // staircase steps, offset counted modulo the step width
         if (pos_x == act_start) begin
            stair_lvl_ff <= s_val;
         end else if (pos_x > act_start && stair_off_ff == '0
                      && stair_q_ff <= RISE_W'(STAIR_LAST)) begin
            if ((SAMPLE_W+2)'(s_val) > rise_ref) rise_ff <= rise_ff + 1'b1;
            stair_lvl_ff <= s_val;
         end
         if (pos_x >= act_start) begin
            if (stair_next == step_w) begin
               stair_off_ff <= '0;
               if (stair_q_ff != '1) stair_q_ff <= stair_q_ff + 1'b1;
            end else begin
               stair_off_ff <= stair_next;
            end
         end

         // multiburst segment peak-to-peak
         if (pos_x >= act_start && seg_idx_ff < IDX_W'(SEGMENT_COUNT)) begin
            if (seg_off_ff == seg_w - 1'b1) begin
               pending_ff[seg_idx_ff[SEL_W-1:0]] <=
                  RESP_W'((SAMPLE_W+1)'(new_max) - (SAMPLE_W+1)'(new_min));
               seg_min_ff <= SAMPLE_W'(32767);
               seg_max_ff <= SAMPLE_W'(-32768);
               seg_off_ff <= '0;
               seg_idx_ff <= seg_idx_ff + 1'b1;
            end else begin
               seg_min_ff <= new_min;
               seg_max_ff <= new_max;
               seg_off_ff <= seg_off_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && status.line_end) test_ff <= status.test_line;
   end

   // line-end division
   logic signed [DIV_W-1:0]     div_numer, div_q;
   logic [SAMPLE_W-1:0]         div_denom;
   logic                        div_done;
   logic signed [DIV_W-1:0]     pavg_ff;
   logic                        pb_ff;
   logic signed [SAMPLE_W-1:0]  black_new_ff;
   logic [SAMPLE_W-1:0]         black_abs;
   logic signed [CONTRAST_W-1:0] prod_ff, cq_ff;

   always_comb begin
      black_abs = black_new_ff[SAMPLE_W-1] ? SAMPLE_W'(-black_new_ff)
                                           : SAMPLE_W'(black_new_ff);
      unique case (cmd.op)
         OP_PULSE: begin
            div_numer = DIV_W'(pulse_acc_ff);
            div_denom = (pulse_width_ff == '0) ? SAMPLE_W'(1) : SAMPLE_W'(pulse_width_ff);
         end
         OP_BAR: begin
            div_numer = DIV_W'(bar_acc_ff);
            div_denom = (bar_width_ff == '0) ? SAMPLE_W'(1) : SAMPLE_W'(bar_width_ff);
         end
         OP_PORCH: begin
            div_numer = DIV_W'(porch_acc_ff);
            div_denom = SAMPLE_W'(porch_width);
         end
         OP_CONTRAST: begin
            div_numer = DIV_W'(prod_ff);
            div_denom = black_abs;
         end
         default: begin
            div_numer = '0;
            div_denom = SAMPLE_W'(1);
         end
      endcase
   end

   vtlc_divider #(.NUM_W(DIV_W), .DEN_W(SAMPLE_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      prod_ff <= CONTRAST_W'(pavg_ff[SAMPLE_W-1:0]) * CONTRAST_W'(CONTRAST_SCALE);
      if (div_done) begin
         unique case (cmd.op)
            OP_PULSE:    pavg_ff      <= div_q;
            OP_BAR:      pb_ff        <= status.go_porch;
            OP_PORCH:    black_new_ff <= SAMPLE_W'(div_q);
            OP_CONTRAST: cq_ff        <= CONTRAST_W'(div_q);
            default: ;
         endcase
      end
   end

   // measurements and result register
   logic [TYPE_W-1:0]            type_in;
   logic signed [SAMPLE_W-1:0]   white_ff, white_in, black_ff, black_in;
   logic signed [CONTRAST_W-1:0] contrast_ff, contrast_in;
   logic [BW_STEP_W-1:0]         bw_ff, bw_in, bw_calc;
   logic                         bw_found;
   logic [RESP_W-1:0]            resp_ff [SEGMENT_COUNT];
   logic [RESP_W-1:0]            resp_in [SEGMENT_COUNT];
   logic [RESP_W-1:0]            resp_out [RESP_OUT_COUNT];
   logic [RESP_W-1:0]            half_ref;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic                         rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]       rsp_data_ff;

   always_comb begin
      half_ref = pending_ff[0] >> 1;
      bw_found = 1'b0;
      bw_calc  = '0;
      for (int k = SEGMENT_COUNT - 1; k >= 0; k--) begin
         if (pending_ff[k] < half_ref) begin
            bw_found = 1'b1;
            bw_calc  = (k + 1 > 7) ? BW_STEP_W'(7) : BW_STEP_W'(k + 1);
         end
      end

      if (!test_ff)                      type_in = TYPE_NONE;
      else if (pb_ff)                    type_in = TYPE_PULSE_BAR;
      else if (cross_ff > CROSS_W'(CROSS_LIMIT)) type_in = TYPE_MULTIBURST;
      else if (rise_ff >= RISE_W'(RISE_LIMIT))   type_in = TYPE_STAIRCASE;
      else                               type_in = TYPE_NONE;

      white_in    = white_ff;
      black_in    = black_ff;
      contrast_in = contrast_ff;
      bw_in       = bw_ff;
      for (int k = 0; k < SEGMENT_COUNT; k++) resp_in[k] = resp_ff[k];
      if (type_in == TYPE_PULSE_BAR) begin
         white_in = pavg_ff[SAMPLE_W-1:0];
         black_in = black_new_ff;
         if (black_new_ff != '0) contrast_in = cq_ff;
      end
      if (type_in == TYPE_MULTIBURST) begin
         for (int k = 0; k < SEGMENT_COUNT; k++) resp_in[k] = pending_ff[k];
         if (bw_found) bw_in = bw_calc;
      end
      count_in = (type_in != TYPE_NONE && count_ff != '1) ? count_ff + 1'b1 : count_ff;
      for (int k = 0; k < RESP_OUT_COUNT; k++)
         resp_out[k] = (k < SEGMENT_COUNT) ? resp_in[k] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff    <= '0;
         black_ff    <= '0;
         contrast_ff <= '0;
         bw_ff       <= '0;
         count_ff    <= '0;
         for (int k = 0; k < SEGMENT_COUNT; k++) resp_ff[k] <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         white_ff    <= white_in;
         black_ff    <= black_in;
         contrast_ff <= contrast_in;
         bw_ff       <= bw_in;
         count_ff    <= count_in;
         for (int k = 0; k < SEGMENT_COUNT; k++) resp_ff[k] <= resp_in[k];
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit)
         rsp_data_ff <= {4'b0, count_in, resp_out[5], resp_out[4], resp_out[3],
                         resp_out[2], resp_out[1], resp_out[0], bw_in, contrast_in,
                         black_in, white_in, type_in};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.line_end  = (pos_x + 1'b1) >= eff_len;
      status.test_line = (ln_val >= first_line_ff) && (ln_val <= last_line_ff);
      status.div_done  = div_done;
      status.go_porch  = (pavg_ff > DIV_W'(LEVEL_LIMIT)) && (div_q > DIV_W'(LEVEL_LIMIT));
      status.black_nz  = div_q != '0;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule

>>> sv/vtlc_ctrl.sv
// vtlc_ctrl: sequencer of the classifier, streams a line then steps the
// line-end divisions and the commit; uses vtlc_pkg
module vtlc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  vtlc_pkg::dp_status_type status,
   output vtlc_pkg::ctrl_cmd_type  cmd
);
   import vtlc_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_STREAM:
            if (req_tvalid && status.line_end)
               state_in = status.test_line ? ST_PULSE : ST_FINISH;
         ST_PULSE:    if (status.div_done) state_in = ST_BAR;
         ST_BAR:      if (status.div_done) state_in = status.go_porch ? ST_PORCH : ST_FINISH;
         ST_PORCH:    if (status.div_done) state_in = status.black_nz ? ST_CONTRAST : ST_FINISH;
         ST_CONTRAST: if (status.div_done) state_in = ST_FINISH;
         ST_FINISH:   if (status.out_free) state_in = ST_STREAM;
         default:     state_in = ST_STREAM;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.take   = 1'b0;
      cmd.div_go = 1'b0;
      cmd.op     = OP_PULSE;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_STREAM: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_PULSE: begin
            cmd.div_go = 1'b1;
            cmd.op     = OP_PULSE;
         end
         ST_BAR: begin
            cmd.div_go = 1'b1;
            cmd.op     = OP_BAR;
         end
         ST_PORCH: begin
            cmd.div_go = 1'b1;
            cmd.op     = OP_PORCH;
         end
         ST_CONTRAST: begin
            cmd.div_go = 1'b1;
            cmd.op     = OP_CONTRAST;
         end
         ST_FINISH: cmd.commit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_STREAM;
      else       state_ff <= state_in;
   end

endmodule

>>> sv/video_test_line_classifier.sv
// video_test_line_classifier: top level, joins the sequencer and the datapath
// depends on vtlc_pkg, vtlc_ctrl, vtlc_datapath (and through it vtlc_divider)
//
// Takes one video sample per cycle while a line streams in; every sample but
// the last of a line is taken back to back and gives no transaction on rsp.
// The last sample of a line gives exactly one rsp transaction. For a line
// outside the test range that result is committed once the output register is
// free. For a test line the block stops taking samples while a shared
// bit-serial divider works out the pulse and bar averages and, for a
// pulse-and-bar line, the back porch level and, if that level is not zero,
// the contrast; each division runs over a DIV_W-bit numerator (DIV_W is the
// accumulator width, 28 at the default line size, but at least 24).
// A finished result waits in an output register, so streaming of the next
// line goes on while rsp is stalled; only the next line end then waits.
module video_test_line_classifier #(
   parameter int MAX_LINE_SAMPLES = 4096,
   parameter int SEGMENT_COUNT    = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_we,
   input  logic [vtlc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [vtlc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // sample stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // low bit up: sample[15:0], line_number[25:16], zero fill
   input  logic [vtlc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // line results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // low bit up: signal_type, white, black, contrast,
   // bandwidth_step, response_0..response_5, detected_count, zero fill
   output logic [vtlc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import vtlc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: streaming, division steps, commit
   vtlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // gathering, arithmetic and output register
   vtlc_datapath #(
      .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
      .SEGMENT_COUNT    (SEGMENT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
